/* design/stx_pkg.sv */
// ----------------------------------------------------------------------------
// stx_pkg
// Shared types, token kinds and scan modes for the source text tokenizer.
// ----------------------------------------------------------------------------
package stx_pkg;

  localparam int POS_W  = 24;
  localparam int LINE_W = 24;
  localparam int KIND_W = 5;
  localparam int MAX_TOK = 4;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 2;

  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd3;
  localparam logic [KIND_W-1:0] K_LBRACK  = 5'd4;
  localparam logic [KIND_W-1:0] K_RBRACK  = 5'd5;
  localparam logic [KIND_W-1:0] K_DOT     = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd7;
  localparam logic [KIND_W-1:0] K_NEWLINE = 5'd8;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd9;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd10;
  localparam logic [KIND_W-1:0] K_EQEQ    = 5'd11;
  localparam logic [KIND_W-1:0] K_BANG    = 5'd12;
  localparam logic [KIND_W-1:0] K_NE      = 5'd13;
  localparam logic [KIND_W-1:0] K_LT      = 5'd14;
  localparam logic [KIND_W-1:0] K_LE      = 5'd15;
  localparam logic [KIND_W-1:0] K_GT      = 5'd16;
  localparam logic [KIND_W-1:0] K_GE      = 5'd17;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd18;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd19;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd20;
  localparam logic [KIND_W-1:0] K_POW     = 5'd21;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd22;
  localparam logic [KIND_W-1:0] K_NUMBER  = 5'd23;
  localparam logic [KIND_W-1:0] K_IMAG    = 5'd24;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd25;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd26;
  localparam logic [KIND_W-1:0] K_EOF     = 5'd27;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd28;

  typedef enum logic [4:0] {
    M_IDLE, M_EQ, M_BANG, M_LESS, M_GREATER, M_STAR, M_COLON, M_J, M_JMINUS,
    M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IM_INT, M_IM_DOT, M_IM_FRAC,
    M_STRING, M_COMMENT
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  col;
    logic              err;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0] tok;
    logic [CNT_W-1:0]   cnt;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                  input logic [POS_W-1:0] start,
                                  input logic [POS_W-1:0] len,
                                  input logic [LINE_W-1:0] line,
                                  input logic [POS_W-1:0] col,
                                  input logic err);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    t.err   = err;
    return t;
  endfunction

endpackage

/* design/stx_if.sv */
// ----------------------------------------------------------------------------
// stx_in_if / stx_out_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface stx_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

interface stx_out_if;
  import stx_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [POS_W-1:0]  lexeme_start;
  logic [POS_W-1:0]  lexeme_length;
  logic [LINE_W-1:0] line_number;
  logic [POS_W-1:0]  column_number;
  logic              any_error;
  logic              last_of_run;
  modport source (output valid, output token_kind, output lexeme_start,
                  output lexeme_length, output line_number, output column_number,
                  output any_error, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input lexeme_start,
                input lexeme_length, input line_number, input column_number,
                input any_error, input last_of_run, output ready);
endinterface

/* design/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Latency: a word's first token is shown the cycle after it is accepted.
// Throughput: one word per cycle while words yield at most one token and the
// output is ready; a word with N tokens holds the input until all are taken.
// Reset: synchronous active-low, scanner idle, start line 1, output empty.
module source_text_tokenizer (
  input  logic                       clk,
  input  logic                       rst_n,
  stx_in_if.sink                     in_ch,
  stx_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [stx_pkg::LINE_W-1:0] cfg_data
);
  import stx_pkg::*;

  batch_t batch;
  logic   acc;
  logic   rdy;

  assign in_ch.ready = rdy;
  assign acc         = in_ch.valid && rdy;

  stx_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .action    (in_ch.action),
    .char_code (in_ch.char_code),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .batch     (batch)
  );

  stx_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .batch    (batch),
    .in_ready (rdy),
    .out_ch   (out_ch)
  );

endmodule

/* design/stx_scan.sv */
// ----------------------------------------------------------------------------
// stx_scan
// Scanner state and the per-word decision logic producing up to four tokens.
// ----------------------------------------------------------------------------
module stx_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       action,
  input  logic [7:0]                 char_code,
  input  logic                       cfg_we,
  input  logic [stx_pkg::LINE_W-1:0] cfg_data,
  output stx_pkg::batch_t            batch
);
  import stx_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]  tb_r, tb_nxt;
  logic [POS_W-1:0]  bp_r, bp_nxt;
  logic [LINE_W-1:0] ln_r, ln_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic              err_r, err_nxt;
  logic [LINE_W-1:0] start_line_r;

  mode_t              m0;
  logic               do_flush, do_idle;
  tok_t [MAX_TOK-1:0] tv;
  logic [CNT_W-1:0]   cv;
  logic [7:0]         c;

  always_comb begin
    c        = char_code;
    m0       = mode_r;
    mode_nxt = mode_r;
    tb_nxt   = tb_r;
    bp_nxt   = bp_r;
    ln_nxt   = ln_r;
    col_nxt  = col_r;
    err_nxt  = err_r;
    tv       = '0;
    cv       = '0;
    do_flush = 1'b0;
    do_idle  = 1'b0;

    if (action) begin
      do_flush = 1'b1;
    end else begin
      case (m0)
        M_EQ, M_BANG, M_LESS, M_GREATER, M_COLON: begin
          if (c == "=") begin
            bp_nxt   = bp_nxt + 1'b1;
            col_nxt  = col_nxt + 1'b1;
            mode_nxt = M_IDLE;
            tv[cv[IDX_W-1:0]] = mk_tok((m0 == M_EQ) ? K_EQEQ : (m0 == M_BANG) ? K_NE :
                                       (m0 == M_LESS) ? K_LE :
                                       (m0 == M_GREATER) ? K_GE : K_ASSIGN,
                                       tb_nxt, POS_W'(2), ln_nxt, col_nxt, err_nxt);
            cv = cv + 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_STAR: begin
          if (c == "*") begin
            bp_nxt   = bp_nxt + 1'b1;
            col_nxt  = col_nxt + 1'b1;
            mode_nxt = M_IDLE;
            tv[cv[IDX_W-1:0]] = mk_tok(K_POW, tb_nxt, POS_W'(2), ln_nxt, col_nxt, err_nxt);
            cv = cv + 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_J: begin
          if (is_digit(c)) begin
            bp_nxt   = bp_nxt + 1'b1;
            col_nxt  = col_nxt + 1'b1;
            mode_nxt = M_IM_INT;
          end else if (c == "-") begin
            mode_nxt = M_JMINUS;
          end else if (is_alpha(c)) begin
            bp_nxt   = bp_nxt + 1'b1;
            col_nxt  = col_nxt + 1'b1;
            mode_nxt = M_IDENT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_JMINUS, M_NUM_DOT, M_IM_DOT: begin
          if (is_digit(c)) begin
            bp_nxt   = bp_nxt + POS_W'(2);
            col_nxt  = col_nxt + POS_W'(2);
            mode_nxt = (m0 == M_NUM_DOT) ? M_NUM_FRAC :
                       (m0 == M_IM_DOT) ? M_IM_FRAC : M_IM_INT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            bp_nxt  = bp_nxt + 1'b1;
            col_nxt = col_nxt + 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_NUM_INT, M_IM_INT: begin
          if (is_digit(c)) begin
            bp_nxt  = bp_nxt + 1'b1;
            col_nxt = col_nxt + 1'b1;
          end else if (c == ".") begin
            mode_nxt = (m0 == M_NUM_INT) ? M_NUM_DOT : M_IM_DOT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_NUM_FRAC, M_IM_FRAC: begin
          if (is_digit(c)) begin
            bp_nxt  = bp_nxt + 1'b1;
            col_nxt = col_nxt + 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_STRING: begin
          bp_nxt  = bp_nxt + 1'b1;
          col_nxt = col_nxt + 1'b1;
          if (c == "\"") begin
            mode_nxt = M_IDLE;
            tv[cv[IDX_W-1:0]] = mk_tok(K_STRING, tb_nxt + 1'b1,
                                       bp_nxt - tb_nxt - POS_W'(2),
                                       ln_nxt, col_nxt, err_nxt);
            cv = cv + 1'b1;
          end else if (c == "\n") begin
            ln_nxt  = ln_nxt + 1'b1;
            col_nxt = POS_W'(1);
          end
        end
        M_COMMENT: begin
          if (c != "\n") begin
            bp_nxt  = bp_nxt + 1'b1;
            col_nxt = col_nxt + 1'b1;
          end else begin
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_flush) begin
      mode_nxt = M_IDLE;
      case (m0)
        M_EQ, M_BANG, M_LESS, M_GREATER, M_STAR: begin
          tv[cv[IDX_W-1:0]] = mk_tok((m0 == M_EQ) ? K_EQ : (m0 == M_BANG) ? K_BANG :
                                     (m0 == M_LESS) ? K_LT :
                                     (m0 == M_GREATER) ? K_GT : K_STAR,
                                     tb_nxt, POS_W'(1), ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        M_COLON: begin
          err_nxt = 1'b1;
          tv[cv[IDX_W-1:0]] = mk_tok(K_ERROR, tb_nxt, POS_W'(1), ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        M_J, M_IDENT, M_JMINUS: begin
          tv[cv[IDX_W-1:0]] = mk_tok(K_IDENT, tb_nxt, bp_nxt - tb_nxt,
                                     ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        M_NUM_INT, M_NUM_FRAC, M_NUM_DOT: begin
          tv[cv[IDX_W-1:0]] = mk_tok(K_NUMBER, tb_nxt, bp_nxt - tb_nxt,
                                     ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        M_IM_INT, M_IM_FRAC, M_IM_DOT: begin
          tv[cv[IDX_W-1:0]] = mk_tok(K_IMAG, tb_nxt + 1'b1, bp_nxt - tb_nxt - 1'b1,
                                     ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        M_STRING: begin
          err_nxt = 1'b1;
          tv[cv[IDX_W-1:0]] = mk_tok(K_ERROR, tb_nxt + 1'b1, bp_nxt - tb_nxt - 1'b1,
                                     ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
        end
        default: begin
        end
      endcase
      if ((m0 == M_JMINUS) || (m0 == M_NUM_DOT) || (m0 == M_IM_DOT)) begin
        tb_nxt  = bp_nxt;
        bp_nxt  = bp_nxt + 1'b1;
        col_nxt = col_nxt + 1'b1;
        tv[cv[IDX_W-1:0]] = mk_tok((m0 == M_JMINUS) ? K_MINUS : K_DOT, tb_nxt,
                                   POS_W'(1), ln_nxt, col_nxt, err_nxt);
        cv = cv + 1'b1;
      end
    end

    if (do_idle) begin
      tb_nxt   = bp_nxt;
      bp_nxt   = bp_nxt + 1'b1;
      col_nxt  = col_nxt + 1'b1;
      mode_nxt = M_IDLE;
      case (c)
        "(", ")", "{", "}", "[", "]", ".", ",", "+", "-", "/", ";", "\n": begin
          tv[cv[IDX_W-1:0]] = mk_tok((c == "(") ? K_LPAREN : (c == ")") ? K_RPAREN :
                                     (c == "{") ? K_LBRACE : (c == "}") ? K_RBRACE :
                                     (c == "[") ? K_LBRACK : (c == "]") ? K_RBRACK :
                                     (c == ".") ? K_DOT : (c == ",") ? K_COMMA :
                                     (c == "+") ? K_PLUS : (c == "-") ? K_MINUS :
                                     (c == "/") ? K_SLASH : K_NEWLINE,
                                     tb_nxt, POS_W'(1), ln_nxt, col_nxt, err_nxt);
          cv = cv + 1'b1;
          if (c == "\n") begin
            ln_nxt  = ln_nxt + 1'b1;
            col_nxt = '0;
          end
        end
        " ", "\r", "\t": begin
        end
        ":": mode_nxt = M_COLON;
        "=": mode_nxt = M_EQ;
        "!": mode_nxt = M_BANG;
        "<": mode_nxt = M_LESS;
        ">": mode_nxt = M_GREATER;
        "*": mode_nxt = M_STAR;
        "#": mode_nxt = M_COMMENT;
        "\"": mode_nxt = M_STRING;
        "j": mode_nxt = M_J;
        default: begin
          if (is_digit(c)) begin
            mode_nxt = M_NUM_INT;
          end else if (is_alpha(c)) begin
            mode_nxt = M_IDENT;
          end else begin
            err_nxt = 1'b1;
            tv[cv[IDX_W-1:0]] = mk_tok(K_ERROR, tb_nxt, POS_W'(1),
                                       ln_nxt, col_nxt, err_nxt);
            cv = cv + 1'b1;
          end
        end
      endcase
    end

    if (action) begin
      tv[cv[IDX_W-1:0]] = mk_tok(K_NEWLINE, bp_nxt, '0, ln_nxt, col_nxt, err_nxt);
      cv = cv + 1'b1;
      tv[cv[IDX_W-1:0]] = mk_tok(K_EOF, bp_nxt, '0, ln_nxt, col_nxt, err_nxt);
      cv = cv + 1'b1;
      mode_nxt = M_IDLE;
      tb_nxt   = '0;
      bp_nxt   = '0;
      ln_nxt   = start_line_r;
      col_nxt  = '0;
      err_nxt  = 1'b0;
    end

    batch.tok = tv;
    batch.cnt = cv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      tb_r         <= '0;
      bp_r         <= '0;
      ln_r         <= LINE_W'(1);
      col_r        <= '0;
      err_r        <= 1'b0;
      start_line_r <= LINE_W'(1);
    end else begin
      if (cfg_we) begin
        start_line_r <= cfg_data;
        if ((bp_r == '0) && (mode_r == M_IDLE)) begin
          ln_r <= cfg_data;
        end
      end
      if (acc) begin
        mode_r <= mode_nxt;
        tb_r   <= tb_nxt;
        bp_r   <= bp_nxt;
        ln_r   <= ln_nxt;
        col_r  <= col_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

/* design/stx_outq.sv */
// ----------------------------------------------------------------------------
// stx_outq
// Result register holding one word's tokens and handing them out in order.
// ----------------------------------------------------------------------------
module stx_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  stx_pkg::batch_t batch,
  output logic            in_ready,
  stx_out_if.source       out_ch
);
  import stx_pkg::*;

  tok_t [MAX_TOK-1:0] tok_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               last;
  logic               take;
  tok_t               cur;

  assign cur      = tok_r[idx_r];
  assign last     = ({1'b0, idx_r} + 1'b1) == cnt_r;
  assign take     = out_ch.valid && out_ch.ready;
  assign in_ready = (cnt_r == '0) || (take && last);

  assign out_ch.valid         = cnt_r != '0;
  assign out_ch.token_kind    = cur.kind;
  assign out_ch.lexeme_start  = cur.start;
  assign out_ch.lexeme_length = cur.len;
  assign out_ch.line_number   = cur.line;
  assign out_ch.column_number = cur.col;
  assign out_ch.any_error     = cur.err;
  assign out_ch.last_of_run   = last;

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= batch.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
      idx_r <= '0;
    end else if (take) begin
      if (last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule
